// ===== sv/utf8_sample_validator_macros.svh =====
// assertion macros shared by the checker
`ifndef UTF8_SAMPLE_VALIDATOR_MACROS_SVH
`define UTF8_SAMPLE_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define USV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while in reset
`define USV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/usv_pkg.sv =====
package usv_pkg;

    // sequence tracking state
    typedef struct packed {
        logic [1:0]  pending;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic        seq_bad;
        logic        failed;
    } usv_state_t;

    // continuation counts
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_TWO  = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR = 2'd3;

    // byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;

    // code point limits
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;

endpackage

// ===== sv/usv_step.sv =====
module usv_step (
    input  usv_pkg::usv_state_t cur,
    input  logic [7:0]          data_byte,
    output usv_pkg::usv_state_t nxt
);
    import usv_pkg::*;

    logic [20:0] acc_shift;
    logic [1:0]  pending_dec;
    logic        cont_bad;
    logic        seq_done_bad;

    assign acc_shift   = {cur.acc[14:0], data_byte[5:0]};
    assign pending_dec = cur.pending - 2'd1;
    assign cont_bad    = (data_byte & CONT_MASK) != CONT_TAG;

    // checks on a completed sequence
    always_comb
    begin
        seq_done_bad = cur.seq_bad | cont_bad;
        if (cur.seq_len == LEN_THREE && acc_shift < CP_MIN3)
            seq_done_bad = 1'b1;
        if (cur.seq_len == LEN_FOUR && acc_shift < CP_MIN4)
            seq_done_bad = 1'b1;
        if (acc_shift > CP_MAX)
            seq_done_bad = 1'b1;
        if (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI)
            seq_done_bad = 1'b1;
    end

    always_comb
    begin
        nxt = cur;
        if (!cur.failed)
        begin
            if (cur.pending == LEN_NONE)
            begin
                case (data_byte) inside
                    [8'h00:8'h7F]:
                    begin
                        nxt = cur;
                    end
                    [LEAD2_LO:LEAD2_HI]:
                    begin
                        nxt.seq_len = LEN_TWO;
                        nxt.pending = LEN_TWO;
                        nxt.acc     = {16'd0, data_byte[4:0]};
                        nxt.seq_bad = 1'b0;
                    end
                    [LEAD3_LO:LEAD3_HI]:
                    begin
                        nxt.seq_len = LEN_THREE;
                        nxt.pending = LEN_THREE;
                        nxt.acc     = {17'd0, data_byte[3:0]};
                        nxt.seq_bad = 1'b0;
                    end
                    [LEAD4_LO:LEAD4_HI]:
                    begin
                        nxt.seq_len = LEN_FOUR;
                        nxt.pending = LEN_FOUR;
                        nxt.acc     = {18'd0, data_byte[2:0]};
                        nxt.seq_bad = 1'b0;
                    end
                    default:
                    begin
                        nxt.failed = 1'b1;
                    end
                endcase
            end
            else if (pending_dec == LEN_NONE)
            begin
                nxt.pending = LEN_NONE;
                nxt.seq_len = LEN_NONE;
                nxt.acc     = '0;
                nxt.seq_bad = 1'b0;
                nxt.failed  = seq_done_bad;
            end
            else
            begin
                nxt.pending = pending_dec;
                nxt.acc     = acc_shift;
                nxt.seq_bad = cur.seq_bad | cont_bad;
            end
        end
    end

endmodule

// ===== sv/utf8_sample_validator.sv =====
// the verdict is registered, out in the cycle after the byte marked last transfers
// throughput: one byte per cycle, no gaps between samples, bar the stall below
// a pending verdict not yet taken stalls only a new last byte; other bytes keep flowing
// the per-byte cost is one pass through the decode/check logic into the state register
// reset (rst_n low, asynchronous): sequence state cleared, no verdict pending
module utf8_sample_validator (
    input  logic       clk,
    input  logic       rst_n,
    // byte channel
    input  logic       data_valid,
    output logic       data_ready,
    input  logic [7:0] data_byte,
    input  logic       last,
    // verdict channel
    output logic       result_valid,
    input  logic       result_ready,
    output logic       valid_res
);
    import usv_pkg::*;

    usv_state_t state_reg;
    usv_state_t state_next;
    usv_state_t step_out;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       res_data_reg;
    logic       res_data_next;
    logic       byte_xfer;
    logic       res_xfer;

    // per-byte decode and checks
    usv_step u_step (
        .cur       (state_reg),
        .data_byte (data_byte),
        .nxt       (step_out)
    );

    // the output register is free if empty or drained this cycle;
    // bytes that are not last never touch it, so they pass regardless
    assign data_ready = !last || !res_valid_reg || result_ready;
    assign byte_xfer  = data_valid && data_ready;
    assign res_xfer   = res_valid_reg && result_ready;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_xfer)
            res_valid_next = 1'b0;
        if (byte_xfer)
        begin
            if (last)
            begin
                // verdict goes out, state starts over for the next sample
                state_next     = '0;
                res_valid_next = 1'b1;
                res_data_next  = !step_out.failed;
            end
            else
            begin
                state_next = step_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // verdict payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign valid_res    = res_data_reg;

endmodule

// ===== sv/usv_checker.sv =====
`include "utf8_sample_validator_macros.svh"

module usv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       data_valid,
    input logic       data_ready,
    input logic [7:0] data_byte,
    input logic       last,
    input logic       result_valid,
    input logic       result_ready,
    input logic       valid_res
);

    // a stalled verdict holds
    `USV_ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(valid_res))

    // a waiting byte holds with its payload
    `USV_ASSERT_NEXT(a_in_hold, clk, rst_n, data_valid && !data_ready, data_valid && $stable(data_byte) && $stable(last))

    // a last-byte transfer always yields a verdict next cycle
    `USV_ASSERT_NEXT(a_last_gives_res, clk, rst_n, data_valid && data_ready && last, result_valid)

    // a verdict comes only from a last-byte transfer or is a held one
    `USV_ASSERT_NOW(a_res_source, clk, rst_n, result_valid, $past(data_valid && data_ready && last) || $past(result_valid && !result_ready))

    // a stalled verdict blocks a new last byte
    `USV_ASSERT_NOW(a_last_blocked, clk, rst_n, result_valid && !result_ready && last, !data_ready)

endmodule

bind utf8_sample_validator usv_checker u_usv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res)
);

// ===== verif/utf8_sample_validator_tb.sv =====
module utf8_sample_validator_tb;

    import usv_pkg::*;

    // scoreboard: tracks the utf-8 decode state and the verdicts still owed by the block
    class utf8_verdict_board;
        usv_state_t st;
        logic       verdicts_due[$];
        int         errors;
        int         live_bytes;

        function new();
            st = '0;
            errors = 0;
            live_bytes = 0;
        endfunction

        // one byte transfer on the input channel
        function void note_byte(logic [7:0] b, logic is_last);
            logic       judged_bad;
            logic [1:0] opened;
            opened = LEN_NONE;
            live_bytes++;
            if (!st.failed)
            begin
                if (st.pending == 2'd0)
                begin
                    if (b < ASCII_LIMIT)
                    begin
                        // plain ascii passes
                    end
                    else if (b >= LEAD2_LO && b <= LEAD2_HI)
                    begin
                        opened = LEN_TWO;
                        st.acc = {16'd0, b[4:0]};
                    end
                    else if (b >= LEAD3_LO && b <= LEAD3_HI)
                    begin
                        opened = LEN_THREE;
                        st.acc = {17'd0, b[3:0]};
                    end
                    else if (b >= LEAD4_LO && b <= LEAD4_HI)
                    begin
                        opened = LEN_FOUR;
                        st.acc = {18'd0, b[2:0]};
                    end
                    else
                    begin
                        st.failed = 1'b1;
                    end
                    if (opened != LEN_NONE)
                    begin
                        st.seq_len = opened;
                        st.pending = opened;
                        st.seq_bad = 1'b0;
                    end
                end
                else
                begin
                    // continuation slot: byte is consumed even if malformed
                    if ((b & CONT_MASK) != CONT_TAG)
                        st.seq_bad = 1'b1;
                    st.acc = {st.acc[14:0], b[5:0]};
                    st.pending = st.pending - 2'd1;
                    if (st.pending == 2'd0)
                    begin
                        judged_bad = st.seq_bad;
                        if (st.seq_len == LEN_THREE && st.acc < CP_MIN3)
                            judged_bad = 1'b1;
                        if (st.seq_len == LEN_FOUR && st.acc < CP_MIN4)
                            judged_bad = 1'b1;
                        if (st.acc > CP_MAX)
                            judged_bad = 1'b1;
                        if (st.acc >= CP_SURR_LO && st.acc <= CP_SURR_HI)
                            judged_bad = 1'b1;
                        if (judged_bad)
                            st.failed = 1'b1;
                        st.seq_len = LEN_NONE;
                        st.acc = '0;
                        st.seq_bad = 1'b0;
                    end
                end
            end
            // an open sequence at the end of the sample is dropped unchecked
            if (is_last)
            begin
                verdicts_due.insert(verdicts_due.size(), !st.failed);
                st = '0;
            end
        endfunction

        // one transfer on the verdict channel
        function void check_verdict(logic got);
            logic want;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $display("%0t: verdict with nothing due, expected none, got %0d", $time, got);
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: valid_res mismatch, expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;   // cycles with no transfer on either channel
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int IDLE_PCT    = 19;
    localparam int ITEM_TARGET = 925;    // directed plus about 900 random bytes

    logic       clk;
    logic       rst_n;
    logic       data_valid;
    logic       data_ready;
    logic [7:0] data_byte;
    logic       last;
    logic       result_valid;
    logic       result_ready;
    logic       valid_res;

    utf8_verdict_board sb = new();

    logic [7:0] sample_q[$];     // bytes of the sample being built
    bit         gaps_on;         // random idling on both sides
    bit         hold_req;        // asks the receiver for a long hold-off
    int         stall_cycles;

    utf8_sample_validator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .valid_res    (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // sample builders
    // ------------------------------------------------------------------

    // append one byte to the sample
    function automatic void add_byte(logic [7:0] b);
        sample_q.insert(sample_q.size(), b);
    endfunction

    // mostly random in range, with a fair share of both ends
    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    // encode cp in exactly len bytes, overlong or out of range if asked
    function automatic void put_seq(int unsigned cp, int len);
        logic [20:0] c;
        c = cp[20:0];
        case (len)
            1: add_byte({1'b0, c[6:0]});
            2:
            begin
                add_byte({3'b110, c[10:6]});
                add_byte({2'b10, c[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, c[15:12]});
                add_byte({2'b10, c[11:6]});
                add_byte({2'b10, c[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, c[20:18]});
                add_byte({2'b10, c[17:12]});
                add_byte({2'b10, c[11:6]});
                add_byte({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // a code point that is legal in the shortest form of this length
    function automatic int unsigned good_cp(int len);
        int unsigned cp;
        case (len)
            1: cp = pick('h0, 'h7F);
            2: cp = pick('h80, 'h7FF);
            3:
            begin
                cp = pick('h800, 'hFFFF);
                // step over the surrogate block, keeping the edge next to it
                if (cp >= 'hD800 && cp <= 'hDFFF)
                    cp = ($urandom_range(1)) ? 'hD7FF : cp + 'h800;
            end
            default: cp = pick('h10000, 'h10FFFF);
        endcase
        return cp;
    endfunction

    function automatic void put_good();
        int len;
        len = $urandom_range(4, 1);
        put_seq(good_cp(len), len);
    endfunction

    function automatic void put_defect();
        int         first;
        int         len;
        logic [7:0] nc;
        case ($urandom_range(6))
            0: put_seq(pick('h0, 'h7FF), 3);                 // overlong 3-byte form
            1: put_seq(pick('h0, 'hFFFF), 4);                // overlong 4-byte form
            2: put_seq(pick('hD800, 'hDFFF), 3);             // surrogate
            3: put_seq(pick('h110000, 'h1FFFFF), 4);         // beyond the unicode range
            4:
            begin
                // byte that can never lead: C0/C1, F5-FF or a stray continuation
                case ($urandom_range(2))
                    0: add_byte(8'hC0 | 8'($urandom_range(1)));
                    1: add_byte(8'($urandom_range(8'hFF, 8'hF5)));
                    default: add_byte(8'($urandom_range(8'hBF, 8'h80)));
                endcase
            end
            5:
            begin
                // multi-byte sequence with one continuation not of the form 10xxxxxx
                first = sample_q.size();
                len = $urandom_range(4, 2);
                put_seq(good_cp(len), len);
                do
                    nc = 8'($urandom_range(255));
                while (nc[7:6] == 2'b10);
                sample_q[$urandom_range(first + len - 1, first + 1)] = nc;
            end
            default:
            begin
                repeat ($urandom_range(6, 1))
                    add_byte(8'($urandom_range(255)));
            end
        endcase
    endfunction

    // mostly well-formed text, some with one defect, some cut short
    function automatic void build_sample();
        int  units;
        int  bad_at;
        bit  broken;
        sample_q.delete();
        units = $urandom_range(6, 1);
        broken = ($urandom_range(99) < 35);
        bad_at = $urandom_range(units - 1);
        for (int i = 0; i < units; i++)
        begin
            if (broken && i == bad_at)
                put_defect();
            else
                put_good();
        end
        // end of sample lands inside a sequence now and then
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(2, 1))
                if (sample_q.size() > 1)
                    void'(sample_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // input channel driver
    // ------------------------------------------------------------------

    // one byte transfer; payload changes only at the falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (gaps_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                @(negedge clk);
                data_valid <= 1'b0;
            end
        end
        @(negedge clk);
        data_valid <= 1'b1;
        data_byte  <= b;
        last       <= is_last;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_sample();
        int n;
        n = sample_q.size();
        for (int i = 0; i < n; i++)
            send_byte(sample_q[i], i == n - 1);
    endtask

    // stop offering and let every verdict come back
    task automatic drain();
        @(negedge clk);
        data_valid <= 1'b0;
        last       <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // verdict channel: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // block must fill up and stall the next last byte
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                result_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // verdict monitor and stall watchdog, both on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_verdict(valid_res);
            if ((data_valid && data_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d verdicts due",
                         $time, STALL_LIMIT, sb.outstanding());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int idx;
        rst_n        = 1'b0;
        data_valid   = 1'b0;
        data_byte    = 8'h00;
        last         = 1'b0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        stall_cycles = 0;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each failure class
        sample_q = '{8'h00};                      // lone ascii, lowest byte
        send_sample();
        sample_q = '{8'h7F, 8'hFF};               // highest byte cannot lead
        send_sample();
        sample_q = '{8'hDF, 8'hBF};               // top of the 2-byte range
        send_sample();
        sample_q = '{8'hE0, 8'h80, 8'h80};        // overlong 3-byte form
        send_sample();
        sample_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; // just above the unicode range
        send_sample();
        sample_q = '{8'hED, 8'hA0, 8'h80};        // surrogate
        send_sample();
        sample_q = '{8'hE1, 8'h41};               // cut short, bad continuation dropped
        send_sample();
        sample_q = '{8'hC0, 8'h41};               // bad lead, rest of sample ignored
        send_sample();
        sample_q = '{8'hF0, 8'h90, 8'h80, 8'h80}; // lowest 4-byte code point
        send_sample();
        sample_q = '{8'hC3, 8'h41};               // bad continuation on completion
        send_sample();

        // random samples
        idx = 0;
        while (sb.live_bytes < ITEM_TARGET)
        begin
            // long stretch with no idling on either side
            gaps_on = !(idx >= 55 && idx < 85);
            if (idx == 12)
                hold_req = 1'b1;
            if (idx == 40)
                drain();
            build_sample();
            send_sample();
            idx++;
        end

        drain();
        repeat (8)
            @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/usv_pkg.sv
sv/usv_step.sv
sv/utf8_sample_validator.sv
sv/usv_checker.sv
verif/utf8_sample_validator_tb.sv
